/* hdl/hdt_pkg.sv */
`default_nettype none
package hdt_pkg;

    localparam int CORDIC_STAGES = 24;
    localparam int ANG_W = 34;
    localparam int Q_W = 31;
    localparam int SQ_STEPS = 31;
    localparam int SQ_W = 2 * SQ_STEPS - 1;
    localparam int RAD_LAT = 3;
    localparam int LATENCY = 3 + RAD_LAT + 1 + CORDIC_STAGES + 1 + 3 + SQ_STEPS
                             + CORDIC_STAGES + 2;

    typedef logic signed [ANG_W-1:0] t_ang;

    localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C234;
    localparam logic [31:0] PI_Q30 = 32'd3373259426;
    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
    localparam logic [Q_W-1:0] ONE_Q30 = 31'h4000_0000;
    localparam logic signed [27:0] LAT_LIMIT = 28'sd90000000;
    localparam logic signed [28:0] LNG_LIMIT = 29'sd180000000;
    localparam logic [28:0] RAD_DIV = 29'd360000000;
    localparam logic [28:0] RAD_HALF = 29'd180000000;
    localparam logic [30:0] RAD_DIV2 = 31'd720000000;
    localparam int RAD_SHIFT = 29;
    localparam logic [63:0] RAD_MUL64 = (64'd3373259426 << RAD_SHIFT) / 64'd360000000;
    localparam logic [32:0] RAD_MUL = RAD_MUL64[32:0];
    localparam logic [30:0] EARTH_2R = 31'd1274200000;
    localparam logic [30:0] HALF_CIRC = 31'd2001508680;
    localparam logic [30:0] RADIUS_RESET = 31'd15000;
    localparam logic [2:0] ADDR_BUFFER_RADIUS = 3'd0;

    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], n[b]};
            if (rem >= {1'b0, d}) begin
                rem = rem - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bitv;
        v = v_in;
        res = '0;
        bitv = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (bitv > v) bitv = bitv >> 2;
        end
        for (int k = 0; k < 32; k++) begin
            if (bitv != 0) begin
                if (v >= res + bitv) begin
                    v = v - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
        end
        return res;
    endfunction

    function automatic logic [31:0] atan_q30(input int i);
        logic [63:0] q62;
        logic signed [63:0] acc;
        logic [63:0] term;
        logic [63:0] sum;
        logic done;
        int e;
        acc = '0;
        done = 1'b0;
        if (i == 0) begin
            q62 = PI_Q62 >> 2;
        end else begin
            for (int k = 0; k < 64; k++) begin
                e = 62 - i * (2 * k + 1);
                if (e < 0) done = 1'b1;
                if (!done) begin
                    term = udiv64(64'd1 << e, 64'(2 * k + 1));
                    if ((k % 2) == 1) acc = acc - $signed(term);
                    else acc = acc + $signed(term);
                end
            end
            q62 = acc;
        end
        sum = q62 + (64'd1 << 31);
        return sum[63:32];
    endfunction

    function automatic logic [31:0] inv_gain();
        logic [63:0] g2;
        logic [63:0] g;
        logic [63:0] q;
        g2 = 64'd1 << 60;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            if (2 * i < 64) g2 = g2 + (g2 >> (2 * i));
        end
        g = isqrt64(g2);
        if (g == 0) g = 64'd1;
        q = udiv64((64'd1 << 60) + (g >> 1), g);
        return q[31:0];
    endfunction

endpackage
`default_nettype wire

/* hdl/hdt_rad.sv */
`default_nettype none
module hdt_rad (
    input  wire logic        i_clk,
    input  wire logic [28:0] i_mag,
    output logic      [31:0] o_rad
);
    import hdt_pkg::*;

    logic [61:0] r_pm;
    logic [60:0] r_np;
    logic [31:0] r_q0;
    logic [60:0] r_qd;
    logic [60:0] r_n2;
    logic [31:0] r_rad;
    logic [31:0] q0;
    logic [60:0] rem;
    logic [31:0] n_rad;

    assign q0 = r_pm[RAD_SHIFT +: 32];

    always_comb begin
        rem = r_n2 - r_qd;
        if (rem[30:0] >= RAD_DIV2) begin
            n_rad = r_q0 + 32'd2;
        end else if (rem[30:0] >= 31'(RAD_DIV)) begin
            n_rad = r_q0 + 32'd1;
        end else begin
            n_rad = r_q0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pm  <= 62'(i_mag) * 62'(RAD_MUL);
        r_np  <= 61'(i_mag) * 61'(PI_Q30) + 61'(RAD_HALF);
        r_q0  <= q0;
        r_qd  <= 61'(q0) * 61'(RAD_DIV);
        r_n2  <= r_np;
        r_rad <= n_rad;
    end

    assign o_rad = r_rad;
endmodule
`default_nettype wire

/* hdl/hdt_sqrt.sv */
`default_nettype none
module hdt_sqrt (
    input  wire logic                     i_clk,
    input  wire logic [hdt_pkg::SQ_W-1:0] i_rad,
    output logic      [hdt_pkg::Q_W-1:0]  o_root
);
    import hdt_pkg::*;

    logic [SQ_W-1:0] r_v   [1:SQ_STEPS];
    logic [SQ_W-1:0] r_res [1:SQ_STEPS];

    for (genvar j = 0; j < SQ_STEPS; j++) begin : g_step
        localparam logic [SQ_W-1:0] BITV = SQ_W'(1) << (SQ_W - 1 - 2 * j);
        logic [SQ_W-1:0] v_in;
        logic [SQ_W-1:0] res_in;
        logic [SQ_W:0]   sum;
        if (j == 0) begin : g_first
            assign v_in = i_rad;
            assign res_in = '0;
        end else begin : g_next
            assign v_in = r_v[j];
            assign res_in = r_res[j];
        end
        assign sum = {1'b0, res_in} + {1'b0, BITV};
        always_ff @(posedge i_clk) begin
            if ({1'b0, v_in} >= sum) begin
                r_v[j+1]   <= v_in - sum[SQ_W-1:0];
                r_res[j+1] <= (res_in >> 1) + BITV;
            end else begin
                r_v[j+1]   <= v_in;
                r_res[j+1] <= res_in >> 1;
            end
        end
    end

    assign o_root = r_res[SQ_STEPS][Q_W-1:0];
endmodule
`default_nettype wire

/* hdl/haversine_distance_threshold.sv */
`default_nettype none
// great-circle distance of two points, haversine formula, earth radius 6371 km
// input channel: one word of four coordinates (signed microdegrees) is taken
//   at each rising edge with start high and busy low; busy stays low, so a
//   new pair may enter every cycle
// result channel: o_valid marks o_distance_cm (cm, capped at half the
//   circumference) and o_within_buffer for exactly one cycle
// throughput one pair per cycle; the path runs through the radian converters,
//   a 24-stage rotation cordic in each of four lanes, two parallel 31-step
//   square-root pipelines and a 24-stage vectoring cordic; o_valid is the
//   accepting edge's start bit carried along the r_vld shift register
// results leave in input order; the receiver cannot stall, and none is needed
// config: apb register 0 at byte address 0, buffer_radius_cm, reset 15000;
//   write it only while no pair is in flight
// reset (synchronous, active low) clears the valid line and the register;
//   pairs in flight at reset are dropped
module haversine_distance_threshold (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [27:0] i_start_lat,
    input  wire logic signed [28:0] i_start_lng,
    input  wire logic signed [27:0] i_end_lat,
    input  wire logic signed [28:0] i_end_lng,
    output logic                    o_valid,
    output logic             [30:0] o_distance_cm,
    output logic                    o_within_buffer,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic        [2:0]  paddr,
    input  wire logic        [31:0] pwdata,
    output logic             [31:0] prdata,
    output logic                    pready
);
    import hdt_pkg::*;

    localparam t_ang K_INIT = t_ang'(inv_gain());

    logic [LATENCY-1:0] r_vld;
    logic [30:0] r_radius;

    logic signed [27:0] r1_slat, r1_elat;
    logic signed [28:0] r1_slng, r1_elng;
    logic signed [27:0] r2_slat, r2_elat;
    logic signed [28:0] r2_slng, r2_elng;
    logic signed [28:0] dlat;
    logic signed [29:0] dlng;
    logic signed [27:0] aslat, aelat;
    logic signed [28:0] adlat;
    logic signed [29:0] adlng;
    logic [28:0] r3_mag [0:3];
    logic [31:0] w_rad [0:3];
    t_ang r4_ang [0:3];
    t_ang w_cx [0:3];
    t_ang w_sy [0:3];
    logic [Q_W-1:0] r5_mag [0:3];
    logic [Q_W-1:0] r6_p1, r6_p2, r6_p3;
    logic [Q_W-1:0] r7_p1, r7_p4;
    logic [Q_W-1:0] r8_a;
    logic [Q_W:0] a_sum;
    logic [Q_W-1:0] w_rx, w_ry;
    t_ang w_ang;
    logic [30:0] ang_pos;
    logic [61:0] r9_prod;
    logic [61:0] dist_sum;
    logic [30:0] dist_cap;
    logic [30:0] r_dist;
    logic r_within;

    function automatic logic [Q_W-1:0] unit_mag(input t_ang v);
        t_ang m;
        m = (v < 0) ? -v : v;
        return (m > t_ang'(ONE_Q30)) ? ONE_Q30 : m[Q_W-1:0];
    endfunction

    function automatic logic [Q_W-1:0] mulq(input logic [Q_W-1:0] a, input logic [Q_W-1:0] b);
        logic [61:0] p;
        p = 62'(a) * 62'(b) + (62'(1) << 29);
        return p[60:30];
    endfunction

    assign busy = 1'b0;
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_BUFFER_RADIUS) ? {1'b0, r_radius} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
            r_vld    <= '0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == ADDR_BUFFER_RADIUS) begin
                r_radius <= pwdata[30:0];
            end
            r_vld <= {r_vld[LATENCY-2:0], start && !busy};
        end
    end

    // input, clamp
    always_ff @(posedge i_clk) begin
        r1_slat <= i_start_lat;
        r1_slng <= i_start_lng;
        r1_elat <= i_end_lat;
        r1_elng <= i_end_lng;
        r2_slat <= (r1_slat > LAT_LIMIT) ? LAT_LIMIT :
                   (r1_slat < -LAT_LIMIT) ? -LAT_LIMIT : r1_slat;
        r2_elat <= (r1_elat > LAT_LIMIT) ? LAT_LIMIT :
                   (r1_elat < -LAT_LIMIT) ? -LAT_LIMIT : r1_elat;
        r2_slng <= (r1_slng > LNG_LIMIT) ? LNG_LIMIT :
                   (r1_slng < -LNG_LIMIT) ? -LNG_LIMIT : r1_slng;
        r2_elng <= (r1_elng > LNG_LIMIT) ? LNG_LIMIT :
                   (r1_elng < -LNG_LIMIT) ? -LNG_LIMIT : r1_elng;
    end

    // magnitudes; latitudes doubled so one divisor serves all four
    always_comb begin
        dlat  = 29'(r2_elat) - 29'(r2_slat);
        dlng  = 30'(r2_elng) - 30'(r2_slng);
        adlat = (dlat < 0) ? -dlat : dlat;
        adlng = (dlng < 0) ? -dlng : dlng;
        aslat = (r2_slat < 0) ? -r2_slat : r2_slat;
        aelat = (r2_elat < 0) ? -r2_elat : r2_elat;
    end

    always_ff @(posedge i_clk) begin
        r3_mag[0] <= adlat[28:0];
        r3_mag[1] <= adlng[28:0];
        r3_mag[2] <= {aslat[27:0], 1'b0};
        r3_mag[3] <= {aelat[27:0], 1'b0};
    end

    for (genvar l = 0; l < 4; l++) begin : g_lane
        t_ang r_x [1:CORDIC_STAGES];
        t_ang r_y [1:CORDIC_STAGES];
        t_ang r_z [1:CORDIC_STAGES];

        hdt_rad u_rad (
            .i_clk (i_clk),
            .i_mag (r3_mag[l]),
            .o_rad (w_rad[l])
        );

        // fold half longitude difference beyond a right angle
        always_ff @(posedge i_clk) begin
            if (l == 1 && w_rad[l] > HALF_PI_Q30) begin
                r4_ang[l] <= t_ang'(PI_Q30 - w_rad[l]);
            end else begin
                r4_ang[l] <= t_ang'(w_rad[l]);
            end
        end

        for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
            localparam t_ang ATAN = t_ang'(atan_q30(i));
            t_ang x_in, y_in, z_in;
            if (i == 0) begin : g_first
                assign x_in = K_INIT;
                assign y_in = '0;
                assign z_in = r4_ang[l];
            end else begin : g_next
                assign x_in = r_x[i];
                assign y_in = r_y[i];
                assign z_in = r_z[i];
            end
            always_ff @(posedge i_clk) begin
                if (z_in >= 0) begin
                    r_x[i+1] <= x_in - (y_in >>> i);
                    r_y[i+1] <= y_in + (x_in >>> i);
                    r_z[i+1] <= z_in - ATAN;
                end else begin
                    r_x[i+1] <= x_in + (y_in >>> i);
                    r_y[i+1] <= y_in - (x_in >>> i);
                    r_z[i+1] <= z_in + ATAN;
                end
            end
        end

        assign w_cx[l] = r_x[CORDIC_STAGES];
        assign w_sy[l] = r_y[CORDIC_STAGES];
    end

    always_ff @(posedge i_clk) begin
        r5_mag[0] <= unit_mag(w_sy[0]);
        r5_mag[1] <= unit_mag(w_sy[1]);
        r5_mag[2] <= unit_mag(w_cx[2]);
        r5_mag[3] <= unit_mag(w_cx[3]);
        r6_p1 <= mulq(r5_mag[0], r5_mag[0]);
        r6_p2 <= mulq(r5_mag[2], r5_mag[3]);
        r6_p3 <= mulq(r5_mag[1], r5_mag[1]);
        r7_p1 <= r6_p1;
        r7_p4 <= mulq(r6_p2, r6_p3);
        r8_a  <= (a_sum > (Q_W+1)'(ONE_Q30)) ? ONE_Q30 : a_sum[Q_W-1:0];
    end

    assign a_sum = (Q_W+1)'(r7_p1) + (Q_W+1)'(r7_p4);

    hdt_sqrt u_sqrt_x (
        .i_clk  (i_clk),
        .i_rad  ({ONE_Q30 - r8_a, 30'd0}),
        .o_root (w_rx)
    );

    hdt_sqrt u_sqrt_y (
        .i_clk  (i_clk),
        .i_rad  ({r8_a, 30'd0}),
        .o_root (w_ry)
    );

    t_ang r_vx [1:CORDIC_STAGES];
    t_ang r_vy [1:CORDIC_STAGES];
    t_ang r_vz [1:CORDIC_STAGES];

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
        localparam t_ang ATAN = t_ang'(atan_q30(i));
        t_ang x_in, y_in, z_in;
        if (i == 0) begin : g_first
            assign x_in = t_ang'(w_rx);
            assign y_in = t_ang'(w_ry);
            assign z_in = '0;
        end else begin : g_next
            assign x_in = r_vx[i];
            assign y_in = r_vy[i];
            assign z_in = r_vz[i];
        end
        always_ff @(posedge i_clk) begin
            if (y_in >= 0) begin
                r_vx[i+1] <= x_in + (y_in >>> i);
                r_vy[i+1] <= y_in - (x_in >>> i);
                r_vz[i+1] <= z_in + ATAN;
            end else begin
                r_vx[i+1] <= x_in - (y_in >>> i);
                r_vy[i+1] <= y_in + (x_in >>> i);
                r_vz[i+1] <= z_in - ATAN;
            end
        end
    end

    assign w_ang = r_vz[CORDIC_STAGES];
    assign ang_pos = (w_ang < 0) ? 31'd0 : w_ang[30:0];

    always_comb begin
        dist_sum = r9_prod + (62'(1) << 29);
        dist_cap = (dist_sum[61:30] > 32'(HALF_CIRC)) ? HALF_CIRC : dist_sum[60:30];
    end

    always_ff @(posedge i_clk) begin
        r9_prod  <= 62'(ang_pos) * 62'(EARTH_2R);
        r_dist   <= dist_cap;
        r_within <= (dist_cap <= r_radius);
    end

    assign o_valid = r_vld[LATENCY-1];
    assign o_distance_cm = r_dist;
    assign o_within_buffer = r_within;
endmodule
`default_nettype wire

/* hdl/hdt_check.sv */
`default_nettype none
module hdt_check (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        o_valid,
    input wire logic [30:0] o_distance_cm,
    input wire logic        o_within_buffer
);
    import hdt_pkg::*;

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

    a_word_delivered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_valid)
        else $error("accepted word not delivered");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LATENCY))
        else $error("result without accepted word");

    a_dist_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_distance_cm <= HALF_CIRC))
        else $error("distance beyond half circumference");

    a_zero_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_distance_cm == 31'd0) |-> o_within_buffer)
        else $error("zero distance not flagged");
endmodule

bind haversine_distance_threshold hdt_check u_check (.*);
`default_nettype wire
